@@ hw/rtl/hasd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hasd_pkg
// Shared constants and types for the height average / slew / deadband block.
// ----------------------------------------------------------------------------
package hasd_pkg;

    localparam int WINDOW      = 10;
    localparam int SAMPLE_BITS = 16;
    localparam int FIELD_W     = 16;
    localparam int CFG_W       = 16;

    localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W    = $clog2(WINDOW + 1);
    localparam int SUM_W    = SAMPLE_BITS + CNT_W;
    localparam int DCNT_W   = $clog2(SUM_W + 1);

    localparam logic [CFG_W-1:0] MAX_STEP_RST = 16'd65535;
    localparam logic [CFG_W-1:0] DEADBAND_RST = 16'd25;

    typedef enum logic {
        REG_MAX_STEP = 1'b0,
        REG_DEADBAND = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ACCUM,
        ST_DIV,
        ST_SLEW,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic capture;   // take the input sample
        logic accum;     // update window, running sum, start divide
        logic div_step;  // one quotient bit
        logic slew;      // update slew-limited value
        logic finish;    // deadband check, load output register
    } cmd_t;

    typedef struct packed {
        logic div_last;  // current divide step is the final one
    } status_t;

endpackage
`default_nettype wire

@@ hw/rtl/height_average_slew_deadband.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// height_average_slew_deadband
// Moving average of height samples, slew limited and deadband filtered.
// ----------------------------------------------------------------------------
// One height sample per input transaction goes into a 10-entry circular
// window; the truncated mean of the samples held so far (fewer until the
// window first fills) is approached by a value that moves at most max_step per
// sample, and the output repeats its last value unless that value differs by
// more than deadband. Every input transaction yields exactly one output
// transaction. From acceptance to a loaded output, a sample passes through
// a window RAM read, a running-sum update, a bit-serial restoring divide by
// the entry count, a slew step and a deadband step. A new sample is taken
// only in the idle state, after the previous one has loaded the output
// register. A result waiting at the output does not stop the next sample
// from being accepted; that sample then waits in its deadband step until
// the output register frees up. Configuration: cfg_addr 0 is max_step,
// 1 is deadband.
// ----------------------------------------------------------------------------
module height_average_slew_deadband
    import hasd_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [FIELD_W-1:0] s_tdata,   // [15:0] raw_height
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic      [FIELD_W-1:0] m_tdata,   // [15:0] smoothed_height
    input  wire logic               cfg_we,
    input  wire logic               cfg_addr,
    input  wire logic [CFG_W-1:0]   cfg_wdata
);
    cmd_t    cmd;
    status_t status;

    hasd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hasd_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire

@@ hw/rtl/hasd_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hasd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hasd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                                       aclk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule
`default_nettype wire

@@ hw/rtl/hasd_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hasd_ctrl
// Sequencer: input handshake, step through window update, serial divide,
// slew and deadband, and the output valid flag.
// ----------------------------------------------------------------------------
module hasd_ctrl
    import hasd_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    input  wire status_t status,
    output cmd_t         cmd
);
    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                cmd.accum  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_SLEW;
                end
            end
            ST_SLEW: begin
                cmd.slew   = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                // wait for the output register to free up
                if (!m_tvalid_reg || m_tready) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.finish) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule
`default_nettype wire

@@ hw/rtl/hasd_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hasd_dpath
// Datapath: sample window RAM, running sum, restoring divider, slew limiter,
// deadband filter, configuration registers and output data register.
// ----------------------------------------------------------------------------
module hasd_dpath
    import hasd_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cmd_t               cmd,
    output status_t                 status,
    input  wire logic               cfg_we,
    input  wire logic               cfg_addr,
    input  wire logic [CFG_W-1:0]   cfg_wdata,
    input  wire logic [FIELD_W-1:0] s_tdata,
    output logic      [FIELD_W-1:0] m_tdata
);
    logic [CFG_W-1:0]       max_step_reg, deadband_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic                   full_reg, full_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [SUM_W-1:0]       quot_reg, quot_next;
    logic [CNT_W-1:0]       rem_reg, rem_next;
    logic [DCNT_W-1:0]      dcnt_reg, dcnt_next;
    logic [SAMPLE_BITS-1:0] slewed_reg, slewed_next;
    logic [SAMPLE_BITS-1:0] reported_reg, reported_next;
    logic [FIELD_W-1:0]     m_tdata_reg;
    logic [SAMPLE_BITS-1:0] old_sample;
    logic [CNT_W:0]         rem_shift;
    logic                   rem_ge;
    logic [SAMPLE_BITS-1:0] mean;
    logic [SAMPLE_BITS-1:0] up_diff, dn_diff, db_diff;
    logic [CFG_W-1:0]       step;

    hasd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW)
    ) u_window (
        .aclk  (aclk),
        .we    (cmd.accum),
        .waddr (slot_reg),
        .wdata (sample_reg),
        .raddr (slot_reg),
        .rdata (old_sample)
    );

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_step_reg <= MAX_STEP_RST;
            deadband_reg <= DEADBAND_RST;
        end else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_addr))
                REG_MAX_STEP: max_step_reg <= cfg_wdata;
                REG_DEADBAND: deadband_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // window bookkeeping and running sum
    always_comb begin
        slot_next  = slot_reg;
        full_next  = full_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        if (cmd.accum) begin
            if (slot_reg == SLOT_W'(WINDOW - 1)) begin
                slot_next = '0;
                full_next = 1'b1;
            end else begin
                slot_next = slot_reg + 1'b1;
            end
            // the overwritten entry only counts once the window has filled
            sum_next = sum_reg + SUM_W'(sample_reg)
                     - (full_reg ? SUM_W'(old_sample) : SUM_W'(0));
            count_next = full_next ? CNT_W'(WINDOW)
                                   : CNT_W'({1'b0, slot_reg} + 1'b1);
        end
    end

    // restoring divider, one quotient bit per cycle
    assign rem_shift = {rem_reg, quot_reg[SUM_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, count_reg});
    assign status.div_last = (dcnt_reg == DCNT_W'(1));

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dcnt_next = dcnt_reg;
        if (cmd.accum) begin
            quot_next = sum_next;
            rem_next  = '0;
            dcnt_next = DCNT_W'(SUM_W);
        end else if (cmd.div_step) begin
            quot_next = {quot_reg[SUM_W-2:0], rem_ge};
            rem_next  = rem_ge ? CNT_W'(rem_shift - {1'b0, count_reg})
                               : rem_shift[CNT_W-1:0];
            dcnt_next = dcnt_reg - 1'b1;
        end
    end

    // slew limiter and deadband
    assign mean    = quot_reg[SAMPLE_BITS-1:0];
    assign step    = max_step_reg;
    assign up_diff = mean - slewed_reg;
    assign dn_diff = slewed_reg - mean;
    assign db_diff = (slewed_reg >= reported_reg) ? (slewed_reg - reported_reg)
                                                  : (reported_reg - slewed_reg);

    always_comb begin
        slewed_next   = slewed_reg;
        reported_next = reported_reg;
        if (cmd.slew) begin
            if (mean > slewed_reg) begin
                slewed_next = (up_diff > step) ? (slewed_reg + step) : mean;
            end else begin
                slewed_next = (dn_diff > step) ? (slewed_reg - step) : mean;
            end
        end
        if (cmd.finish && (db_diff > deadband_reg)) begin
            reported_next = slewed_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg     <= '0;
            full_reg     <= 1'b0;
            sum_reg      <= '0;
            dcnt_reg     <= '0;
            slewed_reg   <= '0;
            reported_reg <= '0;
        end else begin
            slot_reg     <= slot_next;
            full_reg     <= full_next;
            sum_reg      <= sum_next;
            dcnt_reg     <= dcnt_next;
            slewed_reg   <= slewed_next;
            reported_reg <= reported_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sample_reg <= s_tdata[SAMPLE_BITS-1:0];
        end
        count_reg <= count_next;
        quot_reg  <= quot_next;
        rem_reg   <= rem_next;
        if (cmd.finish) begin
            m_tdata_reg <= FIELD_W'(reported_next);
        end
    end

    assign m_tdata = m_tdata_reg;

endmodule
`default_nettype wire
